// File: sv/mle_pkg.sv
package mle_pkg;

  localparam int unsigned CodeW   = 7;
  localparam int unsigned YW      = 12;   // code placed in q12
  localparam int unsigned CodeSh  = YW - CodeW;
  localparam int unsigned PW      = 13;   // 2^y approximation, 4096..8151
  localparam int unsigned RW      = 20;   // running power, below 2^20
  localparam int unsigned CoefW   = 13;
  localparam int unsigned FracW   = 12;
  localparam int unsigned OutW    = 12;
  localparam int unsigned SegW    = 2;

  // one stage forms 2^y, seven stages raise it to the 8th power
  localparam int unsigned NumMul    = 7;
  localparam int unsigned NumStages = NumMul + 1;
  localparam int unsigned StageW    = $clog2(NumStages);

  localparam logic [RW-1:0] Q12One  = RW'(20'h01000);
  localparam logic [YW-1:0] SegSize = YW'(12'h400);
  // (d * 16) >> 12 is a plain right shift
  localparam int unsigned   OutMul  = 'h10;
  localparam int unsigned   OutSh   = FracW - $clog2(OutMul);

  function automatic logic [CoefW-1:0] seg_slope(input logic [SegW-1:0] seg);
    logic [CoefW-1:0] s;
    unique case (seg)
      2'd0:    s = CoefW'(13'h0C19);
      2'd1:    s = CoefW'(13'h0E66);
      2'd2:    s = CoefW'(13'h1127);
      default: s = CoefW'(13'h145A);
    endcase
    return s;
  endfunction

  function automatic logic [CoefW-1:0] seg_offset(input logic [SegW-1:0] seg);
    logic [CoefW-1:0] o;
    unique case (seg)
      2'd0:    o = CoefW'(13'h1000);
      2'd1:    o = CoefW'(13'h0F6D);
      2'd2:    o = CoefW'(13'h0E0C);
      default: o = CoefW'(13'h0BA6);
    endcase
    return o;
  endfunction

endpackage

// File: sv/mu_law_expand_decoder.sv
// mu-law magnitude expander (mu = 255)
//
// input channel: code_i with valid_i, stall_o; a request is taken on a rising
// edge with valid_i high and stall_o low. output channel: sample_q12_o with
// valid_o, stall_i; a result leaves on an edge with valid_o high, stall_i low.
// every code gives exactly one result, in order.
//
// a request passes eight register stages, and valid_o rises once it reaches
// the last one. one stage forms the piecewise-linear 2^y from a 13x12
// multiply, then seven stages each do one 20x13 multiply and shift to raise
// it to the 8th power; the final subtract and shift is read straight off the
// last stage register.
// throughput: one code per cycle while stall_i is low (pipelined multipliers).
//
// reset clears only the stage valid bits. when the receiver stalls, the last
// stage holds; empty stages further up still fill, so stall_o rises only
// once every stage holds a request.
module mu_law_expand_decoder
  import mle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [CodeW-1:0] code_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [OutW-1:0]  sample_q12_o
);

  localparam logic [StageW-1:0] Last = StageW'(NumStages - 1);

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  logic [PW-1:0]        p_q [NumStages];
  logic [RW-1:0]        r_q [NumStages];
  logic [PW-1:0]        p_d;
  logic [RW-1:0]        r_d [NumStages];

  // stage enables: a stage may load when it is empty or its content moves on
  always_comb begin
    en[Last] = !v_q[Last] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  // 2^y by four linear segments
  logic [YW-1:0]         y;
  logic [SegW-1:0]       seg;
  logic [CoefW+YW-1:0]   prod0;
  logic [PW:0]           psum;

  assign y     = {code_i, CodeSh'(0)};
  assign seg   = y[YW-1 -: SegW];
  assign prod0 = (CoefW+YW)'(seg_slope(seg)) * (CoefW+YW)'(y);
  assign psum  = (PW+1)'(prod0[CoefW+YW-1:FracW]) + (PW+1)'(seg_offset(seg));
  assign p_d   = psum[PW-1:0];

  always_comb begin
    r_d[0] = RW'(p_d);
    for (int k = 1; k < NumStages; k++) begin
      logic [RW+PW-1:0] prod;
      prod   = (RW+PW)'(r_q[k-1]) * (RW+PW)'(p_q[k-1]);
      r_d[k] = prod[RW+FracW-1:FracW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      p_q[0] <= p_d;
      r_q[0] <= r_d[0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k] && v_q[k-1]) begin
        p_q[k] <= p_q[k-1];
        r_q[k] <= r_d[k];
      end
    end
  end

  // subtract 1.0, scale by 1/256
  logic [RW-1:0] dq;
  assign dq           = r_q[Last] - Q12One;
  assign valid_o      = v_q[Last];
  assign sample_q12_o = dq[OutSh +: OutW];

  a_power_not_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> r_q[Last] >= Q12One)
    else $error("power stage fell below 1.0");

  a_exp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (p_q[0] >= PW'(Q12One)) && (p_q[0] <= PW'(13'd8151)))
    else $error("2^y approximation out of range");

  a_empty_head_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> !stall_o)
    else $error("stall raised with an empty first stage");

  a_bubble_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !v_q[1] |=> v_q[1])
    else $error("request did not advance into an empty stage");

endmodule
